[hdl/fbba_pkg.sv]
package fbba_pkg;

    // Result status codes.
    localparam logic [1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_FREED     = 2'd2;
    localparam logic [1:0] STAT_BAD_FREE  = 2'd3;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] block_address;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
        logic [8:0]  occupied_count;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decide;
        logic rmw;
        logic scan;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_rmw;
        logic need_scan;
        logic scan_done;
    } stat_t;

endpackage

[hdl/fbba_ctrl.sv]
module fbba_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output fbba_pkg::cmd_t  cmd,
    input  fbba_pkg::stat_t stat
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_RMW    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = stat.need_rmw ? ST_RMW : ST_DONE;
            end
            ST_RMW: begin
                cmd.rmw    = 1'b1;
                state_next = stat.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/fbba_datapath.sv]
module fbba_datapath #(
    parameter int BLOCK_COUNT     = 256,
    parameter int BLOCK_SIZE_LOG2 = 6,
    parameter int BITMAP_WORDS    = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data,
    input  fbba_pkg::in_t   s_data,
    output fbba_pkg::out_t  m_data,
    input  fbba_pkg::cmd_t  cmd,
    output fbba_pkg::stat_t stat
);

    localparam int IDX_W   = $clog2(BLOCK_COUNT + 1);
    localparam int WIDX_W  = IDX_W - 5;
    localparam int WADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [IDX_W-1:0] BC_VAL   = IDX_W'(BLOCK_COUNT);
    localparam logic [IDX_W:0]   BC_VAL_X = (IDX_W + 1)'(BLOCK_COUNT);

    typedef enum logic [1:0] {
        KIND_BUMP   = 2'd0,
        KIND_REUSE  = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // Control state, cleared by reset.
    logic [IDX_W-1:0]        bump_reg, bump_next;
    logic [IDX_W-1:0]        total_reg, total_next;
    logic [IDX_W-1:0]        lfi_reg, lfi_next;
    logic [31:0]             base_reg;
    logic [BITMAP_WORDS-1:0] word_valid_reg;

    // Per-transaction payload.
    fbba_pkg::in_t      in_reg;
    kind_t              kind_reg, kind_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               in_bm_reg, in_bm_next;
    logic [31:0]        grant_reg, grant_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [31:0]        mod_word_reg, mod_word_next;
    logic [WIDX_W-1:0]  scan_w_reg, scan_w_next;
    logic               scan_first_reg, scan_first_next;
    fbba_pkg::out_t     out_reg;

    // Bitmap memory.
    logic [31:0]        bitmap_mem [BITMAP_WORDS];
    logic [31:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_en, mem_we;
    logic [WADDR_W-1:0] rd_addr, wr_addr;
    logic [31:0]        wr_data;

    // Decide stage.
    kind_t             kind_d;
    logic [IDX_W-1:0]  idx_d;
    logic [WIDX_W-1:0] word_d;
    logic              in_bm_d;
    logic [1:0]        rej_status;
    logic [31:0]       off_d, idx_full_d, grant_d;

    // Read-modify-write stage.
    logic [31:0]       word_val, bit_mask;
    logic [IDX_W-1:0]  total_inc, total_dec;
    logic              free_ok, need_scan;

    // Scan stage.
    logic [31:0]       scan_src, scan_masked, low_mask;
    logic [4:0]        pos;
    logic              found, scan_continue;
    logic [IDX_W-1:0]  cand, lfi_scan;
    logic [WIDX_W:0]   wn;
    logic [IDX_W:0]    cand_n;

    always_comb begin
        off_d      = in_reg.block_address - base_reg;
        idx_full_d = off_d >> BLOCK_SIZE_LOG2;
        kind_d     = KIND_REJECT;
        idx_d      = '0;
        rej_status = fbba_pkg::STAT_FULL;
        if (in_reg.func == fbba_pkg::FUNC_ALLOC) begin
            if (bump_reg < BC_VAL) begin
                kind_d = KIND_BUMP;
                idx_d  = bump_reg;
            end else if (total_reg < BC_VAL && lfi_reg < BC_VAL) begin
                kind_d = KIND_REUSE;
                idx_d  = lfi_reg;
            end
        end else begin
            rej_status = fbba_pkg::STAT_BAD_FREE;
            if (idx_full_d < 32'(BLOCK_COUNT)) begin
                kind_d = KIND_FREE;
                idx_d  = IDX_W'(idx_full_d);
            end
        end
        word_d  = idx_d[IDX_W-1:5];
        in_bm_d = 32'(word_d) < 32'(BITMAP_WORDS);
        grant_d = base_reg + (32'(idx_d) << BLOCK_SIZE_LOG2);
    end

    // Blocks past the end of the bitmap always read as free.
    assign word_val  = (in_bm_reg && rd_valid_reg) ? rd_data_reg : 32'd0;
    assign bit_mask  = 32'd1 << idx_reg[4:0];
    assign total_inc = total_reg + IDX_W'(1);
    assign total_dec = total_reg - IDX_W'(1);
    assign free_ok   = ((word_val & bit_mask) != 32'd0) && (total_reg != '0);
    assign need_scan = (kind_reg == KIND_REUSE) && (total_inc < BC_VAL);

    // The first scanned word is the one just modified; later words come from memory.
    always_comb begin
        low_mask    = bit_mask - 32'd1;
        scan_src    = scan_first_reg ? mod_word_reg : (rd_valid_reg ? rd_data_reg : 32'd0);
        scan_masked = scan_first_reg ? (scan_src | low_mask) : scan_src;
        found       = !(&scan_masked);
        pos         = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!scan_masked[i]) begin
                pos = 5'(i);
            end
        end
        cand   = {scan_w_reg, pos};
        wn     = {1'b0, scan_w_reg} + (WIDX_W + 1)'(1);
        cand_n = {wn, 5'd0};
        scan_continue = !found && (cand_n < BC_VAL_X) && (32'(wn) < 32'(BITMAP_WORDS));
        if (found) begin
            lfi_scan = (cand < BC_VAL) ? cand : BC_VAL;
        end else if (cand_n >= BC_VAL_X) begin
            lfi_scan = BC_VAL;
        end else begin
            lfi_scan = IDX_W'(cand_n);
        end
    end

    assign stat.need_rmw  = (kind_d != KIND_REJECT);
    assign stat.need_scan = need_scan;
    assign stat.scan_done = !scan_continue;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = WADDR_W'(word_d);
        if (cmd.decide) begin
            rd_en = in_bm_d;
        end else if (cmd.scan) begin
            rd_en   = scan_continue;
            rd_addr = WADDR_W'(wn);
        end
    end

    assign wr_addr = WADDR_W'(idx_reg[IDX_W-1:5]);
    assign wr_data = (kind_reg == KIND_FREE) ? (word_val & ~bit_mask) : (word_val | bit_mask);
    assign mem_we  = cmd.rmw && in_bm_reg &&
                     ((kind_reg == KIND_BUMP) || (kind_reg == KIND_REUSE) ||
                      ((kind_reg == KIND_FREE) && free_ok));

    always_comb begin
        bump_next       = bump_reg;
        total_next      = total_reg;
        lfi_next        = lfi_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        in_bm_next      = in_bm_reg;
        grant_next      = grant_reg;
        res_status_next = res_status_reg;
        mod_word_next   = mod_word_reg;
        scan_w_next     = scan_w_reg;
        scan_first_next = scan_first_reg;
        if (cmd.decide) begin
            kind_next  = kind_d;
            idx_next   = idx_d;
            in_bm_next = in_bm_d;
            if (kind_d == KIND_REJECT) begin
                res_status_next = rej_status;
                grant_next      = 32'd0;
            end else if (kind_d == KIND_FREE) begin
                res_status_next = fbba_pkg::STAT_FREED;
                grant_next      = 32'd0;
            end else begin
                res_status_next = fbba_pkg::STAT_ALLOCATED;
                grant_next      = grant_d;
            end
        end
        if (cmd.rmw) begin
            // A block with no bitmap bit stays free, so its word scans as all free.
            mod_word_next   = in_bm_reg ? (word_val | bit_mask) : 32'd0;
            scan_w_next     = idx_reg[IDX_W-1:5];
            scan_first_next = 1'b1;
            case (kind_reg)
                KIND_BUMP: begin
                    bump_next  = bump_reg + IDX_W'(1);
                    total_next = total_inc;
                end
                KIND_REUSE: begin
                    total_next = total_inc;
                    if (!need_scan) begin
                        lfi_next = BC_VAL;
                    end
                end
                KIND_FREE: begin
                    if (free_ok) begin
                        total_next = total_dec;
                        if (total_dec == '0) begin
                            bump_next = '0;
                            lfi_next  = BC_VAL;
                        end else if (lfi_reg > idx_reg) begin
                            lfi_next = idx_reg;
                        end
                    end else begin
                        res_status_next = fbba_pkg::STAT_BAD_FREE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.scan) begin
            scan_first_next = 1'b0;
            if (scan_continue) begin
                scan_w_next = WIDX_W'(wn);
            end else begin
                lfi_next = lfi_scan;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bump_reg       <= '0;
            total_reg      <= '0;
            lfi_reg        <= BC_VAL;
            base_reg       <= 32'd0;
            word_valid_reg <= '0;
        end else begin
            bump_reg  <= bump_next;
            total_reg <= total_next;
            lfi_reg   <= lfi_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (mem_we) begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= bitmap_mem[rd_addr];
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        kind_reg       <= kind_next;
        idx_reg        <= idx_next;
        in_bm_reg      <= in_bm_next;
        grant_reg      <= grant_next;
        res_status_reg <= res_status_next;
        mod_word_reg   <= mod_word_next;
        scan_w_reg     <= scan_w_next;
        scan_first_reg <= scan_first_next;
        if (cmd.finish) begin
            out_reg.status          <= res_status_reg;
            out_reg.granted_address <= grant_reg;
            out_reg.occupied_count  <= 9'(total_reg);
        end
    end

    assign m_data = out_reg;

endmodule

[hdl/fixed_block_bitmap_allocator.sv]
// Sequence: a full or out-of-range request passes the decide and done states; an allocation
// or free also passes the read-modify-write state, and an allocation that reuses a freed
// block then scans the bitmap memory for the next free one unless the allocator is now full.
// One transaction at a time: a new one is taken once the last result is registered, and a
// result is registered only once the output holds no earlier result that is not yet taken.
// The bitmap scan reads one word per cycle.
// Reset: synchronous active-low aresetn empties the allocator and clears base_address.
module fixed_block_bitmap_allocator #(
    parameter int BLOCK_COUNT     = 256,
    parameter int BLOCK_SIZE_LOG2 = 6,
    parameter int BITMAP_WORDS    = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  fbba_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output fbba_pkg::out_t m_data
);

    fbba_pkg::cmd_t  cmd;
    fbba_pkg::stat_t stat;

    fbba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    fbba_datapath #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .BLOCK_SIZE_LOG2 (BLOCK_SIZE_LOG2),
        .BITMAP_WORDS    (BITMAP_WORDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Only one transaction is in flight, so acceptance closes the input side.
    a_single_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction was in flight");

    // A result never appears in the cycle right after acceptance.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result produced too early");

    // Only a successful allocation carries an address.
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != fbba_pkg::STAT_ALLOCATED) |->
        (m_data.granted_address == 32'd0))
        else $error("nonzero address on a result that is not an allocation");

endmodule
